[rtl/ntpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpc_pkg
// Shared types, constants and helper functions of the NTP frame classifier.
// ----------------------------------------------------------------------------
package ntpc_pkg;

  // Frame bytes past this position are ignored
  localparam int MAX_FRAME_BYTES = 1536;
  localparam int POS_W           = 11;

  localparam logic [15:0] ETH_ARP        = 16'h0806;
  localparam logic [15:0] ETH_IPV4       = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP     = 8'h01;
  localparam logic [7:0]  PROTO_UDP      = 8'h11;
  localparam logic [15:0] NTP_PORT       = 16'd123;
  localparam logic [15:0] ICMP_ECHO_REQ  = 16'h0800;
  localparam logic [15:0] MAX_UDP_RESET  = 16'd1480;
  localparam logic [5:0]  MIN_IHL_BYTES  = 6'd20;
  localparam logic [3:0]  IP_VERSION4    = 4'd4;

  // Register indexes on the configuration port
  localparam logic REG_LOCAL_IP = 1'b0;
  localparam logic REG_MAX_UDP  = 1'b1;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_DROP = 2'd0,
    VERDICT_ARP  = 2'd1,
    VERDICT_ICMP = 2'd2,
    VERDICT_NTP  = 2'd3
  } verdict_t;

  // Check flag bit positions
  localparam int FL_ARP_FMT     = 0;
  localparam int FL_ARP_TGT     = 1;
  localparam int FL_ARP_DONE    = 2;
  localparam int FL_IP_OK       = 3;
  localparam int FL_IP_DONE     = 4;
  localparam int FL_ICMP_SEEN   = 5;
  localparam int FL_UDP_DELIVER = 6;
  localparam int FLAGS_W        = 7;

  typedef struct packed {
    logic [31:0] local_ip;
    logic [15:0] max_udp_length;
  } cfg_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic        payload_end;
    logic [1:0]  verdict;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [15:0] ip_ident;
    logic [15:0] udp_source_port;
    logic [15:0] payload_length;
    logic [15:0] reply_ip_checksum;
    logic [15:0] reply_icmp_checksum;
  } result_t;

  typedef struct packed {
    logic payload;
    logic summary;
  } push_t;

  // Expected ARP header bytes for Ethernet/IPv4 request
  function automatic logic [7:0] arp_format_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'h00;
      3'd1:    v = 8'h01;
      3'd2:    v = 8'h08;
      3'd3:    v = 8'h00;
      3'd4:    v = 8'h06;
      3'd5:    v = 8'h04;
      3'd6:    v = 8'h00;
      3'd7:    v = 8'h01;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Add one byte into a folded ones'-complement sum
  function automatic logic [15:0] sum_add(input logic [15:0] s, input logic odd,
                                          input logic [7:0] b);
    logic [16:0] t;
    t = {1'b0, s} + (odd ? {9'd0, b} : {1'b0, b, 8'd0});
    return t[16] ? (t[15:0] + 16'd1) : t[15:0];
  endfunction

  // Byte k of the local address, most significant first
  function automatic logic [7:0] ip_byte_of(input logic [31:0] ip, input logic [1:0] k);
    logic [7:0] v;
    case (k)
      2'd0:    v = ip[31:24];
      2'd1:    v = ip[23:16];
      2'd2:    v = ip[15:8];
      2'd3:    v = ip[7:0];
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

[rtl/ntpc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpc_in_if
// Frame byte channel: one frame byte per beat with a last-byte mark.
// ----------------------------------------------------------------------------
interface ntpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, frame_byte, frame_last, input ready);
  modport sink   (input valid, frame_byte, frame_last, output ready);
endinterface

[rtl/ntpc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpc_out_if
// Result channel: payload bytes and end-of-frame summaries, one per beat.
// ----------------------------------------------------------------------------
interface ntpc_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  payload_byte;
  logic        payload_end;
  logic [1:0]  verdict;
  logic [47:0] sender_mac;
  logic [31:0] sender_ip;
  logic [15:0] ip_ident;
  logic [15:0] udp_source_port;
  logic [15:0] payload_length;
  logic [15:0] reply_ip_checksum;
  logic [15:0] reply_icmp_checksum;

  modport source (output valid, item_kind, payload_byte, payload_end, verdict, sender_mac,
                  sender_ip, ip_ident, udp_source_port, payload_length,
                  reply_ip_checksum, reply_icmp_checksum, input ready);
  modport sink   (input valid, item_kind, payload_byte, payload_end, verdict, sender_mac,
                  sender_ip, ip_ident, udp_source_port, payload_length,
                  reply_ip_checksum, reply_icmp_checksum, output ready);
endinterface

[rtl/ntpc_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpc_cfg
// APB-style register file holding the local address and UDP length limit.
// ----------------------------------------------------------------------------
module ntpc_cfg import ntpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [31:0] local_ip_r;
  logic [15:0] max_udp_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r <= '0;
      max_udp_r  <= MAX_UDP_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_LOCAL_IP) local_ip_r <= pwdata;
      if (paddr[2] == REG_MAX_UDP)  max_udp_r  <= pwdata[15:0];
    end
  end

  // Read back
  always_comb begin
    if (paddr[2] == REG_MAX_UDP) prdata = {16'd0, max_udp_r};
    else                         prdata = local_ip_r;
  end

  assign cfg.local_ip       = local_ip_r;
  assign cfg.max_udp_length = max_udp_r;

endmodule

[rtl/ntpc_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpc_parser
// Per-byte header parser: frame state registers and the classification logic.
// ----------------------------------------------------------------------------
module ntpc_parser import ntpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] frame_byte,
  input  logic       frame_last,
  input  cfg_t       cfg,
  output push_t      push,
  output result_t    pay_res,
  output result_t    sum_res
);

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [15:0]        kind_r, kind_nxt;
  logic [47:0]        mac_r, mac_nxt;
  logic [5:0]         hl_r, hl_nxt;
  logic [15:0]        total_r, total_nxt;
  logic [7:0]         proto_r, proto_nxt;
  logic [31:0]        sip_r, sip_nxt;
  logic [15:0]        ident_r, ident_nxt;
  logic [FLAGS_W-1:0] flags_r, flags_nxt;
  logic [47:0]        udp_r, udp_nxt;
  logic [15:0]        icmp_r, icmp_nxt;
  logic [15:0]        hsum_r, hsum_nxt;
  logic [15:0]        msum_r, msum_nxt;
  logic [15:0]        rem_r, rem_nxt;

  logic [POS_W-1:0]   p;
  logic [POS_W-1:0]   ao;
  logic [11:0]        o;
  logic [11:0]        hdr_end;
  logic [5:0]         hl;
  logic [1:0]         verdict;

  always_comb begin
    pos_nxt   = pos_r;   kind_nxt  = kind_r;  mac_nxt   = mac_r;
    hl_nxt    = hl_r;    total_nxt = total_r; proto_nxt = proto_r;
    sip_nxt   = sip_r;   ident_nxt = ident_r; flags_nxt = flags_r;
    udp_nxt   = udp_r;   icmp_nxt  = icmp_r;  hsum_nxt  = hsum_r;
    msum_nxt  = msum_r;  rem_nxt   = rem_r;
    push      = '0;
    pay_res   = '0;
    sum_res   = '0;
    p         = pos_r;
    ao        = pos_r - POS_W'(14);
    hl        = hl_r;
    hdr_end   = 12'd14 + {6'd0, hl_r};
    o         = '0;
    verdict   = VERDICT_DROP;

    if (take) begin
      // Parse the byte while inside the kept window
      if (32'(pos_r) < MAX_FRAME_BYTES) begin
        if (p >= POS_W'(6) && p < POS_W'(12)) begin
          mac_nxt = {mac_r[39:0], frame_byte};
        end else if (p == POS_W'(12) || p == POS_W'(13)) begin
          kind_nxt = {kind_r[7:0], frame_byte};
          if (p == POS_W'(13)) begin
            flags_nxt = '0;
            flags_nxt[FL_ARP_FMT] = 1'b1;
            flags_nxt[FL_ARP_TGT] = 1'b1;
            flags_nxt[FL_IP_OK]   = 1'b1;
          end
        end else if (p >= POS_W'(14)) begin
          if (kind_r == ETH_ARP) begin
            // ARP body
            if (ao < POS_W'(8) && frame_byte != arp_format_byte(ao[2:0]))
              flags_nxt[FL_ARP_FMT] = 1'b0;
            if (ao >= POS_W'(14) && ao < POS_W'(18))
              sip_nxt = {sip_r[23:0], frame_byte};
            if (ao >= POS_W'(24) && ao < POS_W'(28)) begin
              if (frame_byte != ip_byte_of(cfg.local_ip, ao[1:0]))
                flags_nxt[FL_ARP_TGT] = 1'b0;
              if (ao == POS_W'(27)) flags_nxt[FL_ARP_DONE] = 1'b1;
            end
          end else if (kind_r == ETH_IPV4) begin
            // IPv4 header fields
            if (p == POS_W'(14)) begin
              hl     = {frame_byte[3:0], 2'b00};
              hl_nxt = hl;
              if (frame_byte[7:4] != IP_VERSION4 || hl < MIN_IHL_BYTES)
                flags_nxt[FL_IP_OK] = 1'b0;
            end
            hdr_end = 12'd14 + {6'd0, hl};
            if (p == POS_W'(16) || p == POS_W'(17)) total_nxt = {total_r[7:0], frame_byte};
            if (p == POS_W'(18) || p == POS_W'(19)) ident_nxt = {ident_r[7:0], frame_byte};
            if (p == POS_W'(23)) proto_nxt = frame_byte;
            if (p >= POS_W'(26) && p < POS_W'(30)) sip_nxt = {sip_r[23:0], frame_byte};
            if (p >= POS_W'(30) && p < POS_W'(34)) begin
              if (frame_byte != ip_byte_of(cfg.local_ip, p[1:0] - 2'd2))
                flags_nxt[FL_IP_OK] = 1'b0;
              if (p == POS_W'(33)) flags_nxt[FL_IP_DONE] = 1'b1;
            end
            if ({1'b0, p} < hdr_end && p != POS_W'(24) && p != POS_W'(25))
              hsum_nxt = sum_add(hsum_r, p[0], frame_byte);

            // Transport part
            if (hl >= MIN_IHL_BYTES && {1'b0, p} >= hdr_end) begin
              o = {1'b0, p} - hdr_end;
              if (proto_r == PROTO_ICMP) begin
                if (o < 12'd2) icmp_nxt = {icmp_r[7:0], frame_byte};
                if (o == 12'd1) flags_nxt[FL_ICMP_SEEN] = 1'b1;
                if ({6'd0, p} < 17'd14 + {1'b0, total_r}) begin
                  if (o == 12'd0 || o == 12'd2 || o == 12'd3)
                    msum_nxt = sum_add(msum_r, p[0], 8'd0);
                  else
                    msum_nxt = sum_add(msum_r, p[0], frame_byte);
                end
              end else if (proto_r == PROTO_UDP) begin
                if (o < 12'd6) begin
                  udp_nxt = {udp_r[39:0], frame_byte};
                  if (o == 12'd5 && flags_r[FL_IP_OK] && flags_r[FL_IP_DONE] &&
                      udp_nxt[31:16] == NTP_PORT && udp_nxt[15:0] >= 16'd8 &&
                      udp_nxt[15:0] <= cfg.max_udp_length) begin
                    flags_nxt[FL_UDP_DELIVER] = 1'b1;
                    rem_nxt = udp_nxt[15:0] - 16'd8;
                  end
                end else if (o >= 12'd8 && flags_r[FL_UDP_DELIVER] && rem_r != 16'd0) begin
                  // Deliver one payload byte
                  rem_nxt              = rem_r - 16'd1;
                  push.payload         = 1'b1;
                  pay_res.item_kind    = KIND_PAYLOAD;
                  pay_res.payload_byte = frame_byte;
                  pay_res.payload_end  = (rem_nxt == 16'd0) || frame_last ||
                                         (32'(p) + 1 >= MAX_FRAME_BYTES);
                end
              end
            end
          end
        end
        pos_nxt = pos_r + POS_W'(1);
      end

      // Close the frame with a summary
      if (frame_last) begin
        push.summary       = 1'b1;
        sum_res.item_kind  = KIND_SUMMARY;
        sum_res.sender_mac = mac_nxt;
        if (kind_nxt == ETH_ARP) begin
          sum_res.sender_ip = sip_nxt;
          if (flags_nxt[FL_ARP_FMT] && flags_nxt[FL_ARP_TGT] && flags_nxt[FL_ARP_DONE])
            verdict = VERDICT_ARP;
        end else if (kind_nxt == ETH_IPV4) begin
          sum_res.sender_ip = sip_nxt;
          sum_res.ip_ident  = ident_nxt;
          if (flags_nxt[FL_UDP_DELIVER]) begin
            verdict                 = VERDICT_NTP;
            sum_res.udp_source_port = udp_nxt[47:32];
            sum_res.payload_length  = udp_nxt[15:0] - 16'd8 - rem_nxt;
          end else if (proto_nxt == PROTO_ICMP && flags_nxt[FL_IP_OK] &&
                       flags_nxt[FL_IP_DONE] && flags_nxt[FL_ICMP_SEEN] &&
                       icmp_nxt == ICMP_ECHO_REQ) begin
            verdict                     = VERDICT_ICMP;
            sum_res.reply_ip_checksum   = ~hsum_nxt;
            sum_res.reply_icmp_checksum = ~msum_nxt;
          end
        end
        sum_res.verdict = verdict;

        // Clear frame state
        pos_nxt   = '0; kind_nxt  = '0; mac_nxt   = '0; hl_nxt    = '0;
        total_nxt = '0; proto_nxt = '0; sip_nxt   = '0; ident_nxt = '0;
        flags_nxt = '0; udp_nxt   = '0; icmp_nxt  = '0; hsum_nxt  = '0;
        msum_nxt  = '0; rem_nxt   = '0;
      end
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0; kind_r  <= '0; mac_r   <= '0; hl_r    <= '0;
      total_r <= '0; proto_r <= '0; sip_r   <= '0; ident_r <= '0;
      flags_r <= '0; udp_r   <= '0; icmp_r  <= '0; hsum_r  <= '0;
      msum_r  <= '0; rem_r   <= '0;
    end else begin
      pos_r   <= pos_nxt;   kind_r  <= kind_nxt;  mac_r   <= mac_nxt;
      hl_r    <= hl_nxt;    total_r <= total_nxt; proto_r <= proto_nxt;
      sip_r   <= sip_nxt;   ident_r <= ident_nxt; flags_r <= flags_nxt;
      udp_r   <= udp_nxt;   icmp_r  <= icmp_nxt;  hsum_r  <= hsum_nxt;
      msum_r  <= msum_nxt;  rem_r   <= rem_nxt;
    end
  end

endmodule

[rtl/ntpc_out_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntpc_out_queue
// Four-entry result queue; takes up to two results per beat, gives one.
// ----------------------------------------------------------------------------
module ntpc_out_queue import ntpc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  input  result_t pay_res,
  input  result_t sum_res,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t     mem_r [4];
  logic [1:0]  wr_r, rd_r;
  logic [2:0]  count_r, count_nxt;
  logic [1:0]  n_push;
  logic        pop;

  assign room      = (count_r <= 3'd2);
  assign out_valid = (count_r != 3'd0);
  assign out_data  = mem_r[rd_r];
  assign pop       = out_valid & out_ready;
  assign n_push    = {1'b0, push.payload} + {1'b0, push.summary};
  assign count_nxt = count_r + {1'b0, n_push} - {2'd0, pop};

  // Store results, payload beat ahead of the summary
  always_ff @(posedge clk) begin
    if (push.payload) begin
      mem_r[wr_r] <= pay_res;
      if (push.summary) mem_r[wr_r + 2'd1] <= sum_res;
    end else if (push.summary) begin
      mem_r[wr_r] <= sum_res;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_r + n_push;
      rd_r    <= rd_r + {1'b0, pop};
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'd4)
    else $error("result queue overfilled");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> count_r == $past(count_nxt))
    else $error("fill count lost track of pushes and pops");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != 3'd4) |-> (wr_r - rd_r) == count_r[1:0])
    else $error("queue pointers disagree with fill count");

  a_double_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.payload && push.summary) |-> count_r <= 3'd2)
    else $error("double push without room");

endmodule

[rtl/ntp_frame_receive_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_frame_receive_classifier
// Each result is registered into the result queue on its frame byte beat and leaves the queue in order.
// Throughput: one frame byte per cycle; the four-entry result queue absorbs the
// extra summary beat at end of frame, so input stalls only on output backpressure.
// Reset (synchronous, rst_n low): frame state and queue cleared, local_ip = 0,
// max_udp_length = 1480.
// ----------------------------------------------------------------------------
module ntp_frame_receive_classifier import ntpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ntpc_in_if.sink     in_ch,
  ntpc_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t    cfg;
  push_t   push;
  result_t pay_res, sum_res, head;
  logic    room, take;

  assign in_ch.ready = room;
  assign take        = in_ch.valid & room;

  ntpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  ntpc_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .frame_byte (in_ch.frame_byte),
    .frame_last (in_ch.frame_last),
    .cfg        (cfg),
    .push       (push),
    .pay_res    (pay_res),
    .sum_res    (sum_res)
  );

  ntpc_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pay_res   (pay_res),
    .sum_res   (sum_res),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (head)
  );

  // Drive the result beat
  assign out_ch.item_kind           = head.item_kind;
  assign out_ch.payload_byte        = head.payload_byte;
  assign out_ch.payload_end         = head.payload_end;
  assign out_ch.verdict             = head.verdict;
  assign out_ch.sender_mac          = head.sender_mac;
  assign out_ch.sender_ip           = head.sender_ip;
  assign out_ch.ip_ident            = head.ip_ident;
  assign out_ch.udp_source_port     = head.udp_source_port;
  assign out_ch.payload_length      = head.payload_length;
  assign out_ch.reply_ip_checksum   = head.reply_ip_checksum;
  assign out_ch.reply_icmp_checksum = head.reply_icmp_checksum;

endmodule
